@@ hw/rtl/d2q9m_pkg.sv @@
package d2q9m_pkg;

  localparam int unsigned FRAC_BITS = 14;

  localparam int unsigned FW   = 16;
  localparam int unsigned SW   = FW + 2;
  localparam int unsigned RW   = 20;
  localparam int unsigned VW   = 16;
  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned CW   = $clog2(QW);
  localparam int unsigned REMW = RW + 1;

  localparam logic [31:0] NEG_LIMIT = 32'd32768;
  localparam logic [31:0] POS_LIMIT = 32'd32767;

  // quotient magnitude clipped to the 16-bit signed range of its sign
  function automatic logic [VW-1:0] sat_mag(input logic [QW-1:0] q, input logic neg);
    logic [31:0] qw;
    logic [VW-1:0] res;
    qw = 32'(q);
    if (neg) begin
      res = (qw > NEG_LIMIT) ? VW'(NEG_LIMIT) : qw[VW-1:0];
    end else begin
      res = (qw > POS_LIMIT) ? VW'(POS_LIMIT) : qw[VW-1:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/d2q9_moments_with_reduction.sv @@
// An accepted cell passes through SETUP (density, signs, remainders), DIV and FIN, where the
// result is written to the output register; the next cell is taken only after FIN. The restoring
// dividers produce one quotient bit per cycle for x and y side by side.
// A finished result waits in the output register while the next cell is taken in.
// Reset (rst_ni low, asynchronous) empties the datapath and clears the grid statistics.
module d2q9_moments_with_reduction (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // f_rest, f_east, f_north, f_west, f_south, f_northeast, f_northwest, f_southwest,
  // f_southeast, 16 bits each
  input  logic [143:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,   // last_cell
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // density, vel_x, vel_y, density_min, density_max, peak_abs_vx, peak_abs_vy, 4 zero bits
  output logic [127:0] m_axis_tdata_o,
  output logic         m_axis_tuser_o,   // zero_density
  output logic         m_axis_tlast_o    // grid_done
);
  import d2q9m_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  logic [FW-1:0]   f_in [9];
  logic            last_q, last_d;
  logic [SW-1:0]   px_q, px_d, nx_q, nx_d, py_q, py_d, ny_q, ny_d, rest_q, rest_d;
  logic [RW-1:0]   rho_q, rho_d;
  logic            negx_q, negx_d, negy_q, negy_d;
  logic [REMW-1:0] remx_q, remx_d, remy_q, remy_d;
  logic [QW-1:0]   qx_q, qx_d, qy_q, qy_d;

  logic [RW-1:0]   min_q, min_d, max_q, max_d;
  logic [VW-1:0]   pkx_q, pkx_d, pky_q, pky_d;
  logic            first_q, first_d;

  logic [RW-1:0]   odens_q, odens_d, omin_q, omin_d, omax_q, omax_d;
  logic [VW-1:0]   ovx_q, ovx_d, ovy_q, ovy_d, opkx_q, opkx_d, opky_q, opky_d;
  logic            ozero_q, ozero_d, olast_q, olast_d;

  logic            in_go, fin_go, zero;
  logic [REMW:0]   diffx, diffy;
  logic            gex, gey;
  logic [VW-1:0]   magx, magy;
  logic [RW-1:0]   nmin, nmax;
  logic [VW-1:0]   npkx, npky;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      f_in[i] = s_axis_tdata_i[FW*i +: FW];
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_go  = s_axis_tvalid_i && s_axis_tready_o;
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);
  assign zero   = (rho_q == '0);

  assign diffx = {1'b0, remx_q} - (REMW+1)'(rho_q);
  assign diffy = {1'b0, remy_q} - (REMW+1)'(rho_q);
  assign gex   = ~diffx[REMW];
  assign gey   = ~diffy[REMW];

  always_comb begin
    magx = zero ? '0 : sat_mag(qx_q, negx_q);
    magy = zero ? '0 : sat_mag(qy_q, negy_q);
    if (first_q) begin
      nmin = rho_q;
      nmax = rho_q;
      npkx = magx;
      npky = magy;
    end else begin
      nmin = (rho_q < min_q) ? rho_q : min_q;
      nmax = (rho_q > max_q) ? rho_q : max_q;
      npkx = (magx > pkx_q) ? magx : pkx_q;
      npky = (magy > pky_q) ? magy : pky_q;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    px_d    = px_q;
    nx_d    = nx_q;
    py_d    = py_q;
    ny_d    = ny_q;
    rest_d  = rest_q;
    rho_d   = rho_q;
    negx_d  = negx_q;
    negy_d  = negy_q;
    remx_d  = remx_q;
    remy_d  = remy_q;
    qx_d    = qx_q;
    qy_d    = qy_q;
    min_d   = min_q;
    max_d   = max_q;
    pkx_d   = pkx_q;
    pky_d   = pky_q;
    first_d = first_q;
    odens_d = odens_q;
    omin_d  = omin_q;
    omax_d  = omax_q;
    ovx_d   = ovx_q;
    ovy_d   = ovy_q;
    opkx_d  = opkx_q;
    opky_d  = opky_q;
    ozero_d = ozero_q;
    olast_d = olast_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_go) begin
          last_d  = s_axis_tlast_i;
          px_d    = SW'(f_in[1]) + SW'(f_in[5]) + SW'(f_in[8]);
          nx_d    = SW'(f_in[3]) + SW'(f_in[6]) + SW'(f_in[7]);
          py_d    = SW'(f_in[2]) + SW'(f_in[5]) + SW'(f_in[6]);
          ny_d    = SW'(f_in[4]) + SW'(f_in[7]) + SW'(f_in[8]);
          rest_d  = SW'(f_in[0]) + SW'(f_in[2]) + SW'(f_in[4]);
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        rho_d   = RW'(rest_q) + RW'(px_q) + RW'(nx_q);
        negx_d  = nx_q > px_q;
        negy_d  = ny_q > py_q;
        remx_d  = REMW'((nx_q > px_q) ? (nx_q - px_q) : (px_q - nx_q));
        remy_d  = REMW'((ny_q > py_q) ? (ny_q - py_q) : (py_q - ny_q));
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        remx_d = {(gex ? diffx[RW-1:0] : remx_q[RW-1:0]), 1'b0};
        remy_d = {(gey ? diffy[RW-1:0] : remy_q[RW-1:0]), 1'b0};
        qx_d   = {qx_q[QW-2:0], gex};
        qy_d   = {qy_q[QW-2:0], gey};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CW'(QW-1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          odens_d = rho_q;
          ovx_d   = negx_q ? VW'(VW'(0) - magx) : magx;
          ovy_d   = negy_q ? VW'(VW'(0) - magy) : magy;
          omin_d  = nmin;
          omax_d  = nmax;
          opkx_d  = npkx;
          opky_d  = npky;
          ozero_d = zero;
          olast_d = last_q;
          out_valid_d = 1'b1;
          if (last_q) begin
            min_d   = '0;
            max_d   = '0;
            pkx_d   = '0;
            pky_d   = '0;
            first_d = 1'b1;
          end else begin
            min_d   = nmin;
            max_d   = nmax;
            pkx_d   = npkx;
            pky_d   = npky;
            first_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      min_q       <= '0;
      max_q       <= '0;
      pkx_q       <= '0;
      pky_q       <= '0;
      first_q     <= 1'b1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      min_q       <= min_d;
      max_q       <= max_d;
      pkx_q       <= pkx_d;
      pky_q       <= pky_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    px_q    <= px_d;
    nx_q    <= nx_d;
    py_q    <= py_d;
    ny_q    <= ny_d;
    rest_q  <= rest_d;
    rho_q   <= rho_d;
    negx_q  <= negx_d;
    negy_q  <= negy_d;
    remx_q  <= remx_d;
    remy_q  <= remy_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
    odens_q <= odens_d;
    omin_q  <= omin_d;
    omax_q  <= omax_d;
    ovx_q   <= ovx_d;
    ovy_q   <= ovy_d;
    opkx_q  <= opkx_d;
    opky_q  <= opky_d;
    ozero_q <= ozero_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, opky_q, opkx_q, omax_q, omin_q, ovy_q, ovx_q, odens_q};
  assign m_axis_tuser_o  = ozero_q;
  assign m_axis_tlast_o  = olast_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_go |=> state_q == ST_SETUP)
    else $error("accepted cell did not start setup");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == CW'(QW-1)) |=> state_q == ST_FIN)
    else $error("divider did not finish after all quotient bits");

  a_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ozero_q |-> (ovx_q == '0) && (ovy_q == '0) && (odens_q == '0))
    else $error("zero density with non-zero velocity");

  a_density_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (omin_q <= odens_q) && (odens_q <= omax_q))
    else $error("density outside running min/max");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (opkx_q >= (ovx_q[VW-1] ? VW'(VW'(0) - ovx_q) : ovx_q)) &&
                    (opky_q >= (ovy_q[VW-1] ? VW'(VW'(0) - ovy_q) : ovy_q)))
    else $error("velocity magnitude exceeds running peak");

endmodule

@@ tb/sv/d2q9_moments_with_reduction_tb.sv @@
module d2q9_moments_with_reduction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import d2q9m_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_CELLS = 390;
  localparam int unsigned STREAM_CELLS = 60;

  // populations, f_rest in the lowest bits
  typedef struct packed {
    logic [FW-1:0] f_southeast;
    logic [FW-1:0] f_southwest;
    logic [FW-1:0] f_northwest;
    logic [FW-1:0] f_northeast;
    logic [FW-1:0] f_south;
    logic [FW-1:0] f_west;
    logic [FW-1:0] f_north;
    logic [FW-1:0] f_east;
    logic [FW-1:0] f_rest;
  } pops_t;

  typedef struct {
    logic [RW-1:0] density;
    logic [VW-1:0] vel_x;
    logic [VW-1:0] vel_y;
    logic [RW-1:0] density_min;
    logic [RW-1:0] density_max;
    logic [VW-1:0] peak_abs_vx;
    logic [VW-1:0] peak_abs_vy;
    logic          zero_density;
    logic          grid_done;
  } moments_t;

  typedef enum int unsigned {
    GEN_FULL,
    GEN_SMALL,
    GEN_DRIFT,
    GEN_SPARSE,
    GEN_REST_HEAVY
  } gen_mode_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;  // f_rest .. f_southeast, 16 bits each
  logic         s_axis_tlast_i = 1'b0; // last_cell
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // density, vel_x, vel_y, density_min, density_max, peak_abs_vx, peak_abs_vy, 4 zero bits
  logic [127:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;        // zero_density
  logic         m_axis_tlast_o;        // grid_done

  d2q9_moments_with_reduction dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  moments_t    pending_moments[$];
  logic [RW-1:0] grid_min;
  logic [RW-1:0] grid_max;
  logic [VW-1:0] grid_peak_vx;
  logic [VW-1:0] grid_peak_vy;
  logic          grid_fresh = 1'b1;

  int unsigned n_errors = 0;
  int unsigned n_cells = 0;
  int unsigned n_checked = 0;
  int unsigned n_grids = 0;
  int unsigned n_zero_cells = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_request = 0;
  int unsigned longest_in_stall = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("d2q9_moments_with_reduction regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t result %0d: %s", $realtime, n_checked, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // truncated signed quotient, magnitude returned separately
  function automatic logic [VW-1:0] velocity_q(input logic [17:0] pos_sum,
                                              input logic [17:0] neg_sum,
                                              input logic [RW-1:0] rho,
                                              output logic [VW-1:0] mag);
    logic        neg_dir;
    logic [63:0] diff;
    logic [63:0] quo;
    neg_dir = neg_sum > pos_sum;
    diff = neg_dir ? 64'(neg_sum - pos_sum) : 64'(pos_sum - neg_sum);
    if (rho == '0) begin
      mag = '0;
      return '0;
    end
    quo = (diff << FRAC_BITS) / 64'(rho);
    if (neg_dir) begin
      if (quo > 64'd32768) quo = 64'd32768;
      mag = quo[VW-1:0];
      return VW'(64'd0 - quo);
    end
    if (quo > 64'd32767) quo = 64'd32767;
    mag = quo[VW-1:0];
    return quo[VW-1:0];
  endfunction

  function automatic void predict_cell(input pops_t p, input logic is_last);
    moments_t      m;
    logic [17:0]   xp, xn, yp, yn;
    logic [RW-1:0] rho;
    logic [VW-1:0] ax, ay;
    rho = RW'(p.f_rest) + RW'(p.f_east) + RW'(p.f_north) + RW'(p.f_west) + RW'(p.f_south)
        + RW'(p.f_northeast) + RW'(p.f_northwest) + RW'(p.f_southwest) + RW'(p.f_southeast);
    xp = 18'(p.f_east) + 18'(p.f_northeast) + 18'(p.f_southeast);
    xn = 18'(p.f_west) + 18'(p.f_northwest) + 18'(p.f_southwest);
    yp = 18'(p.f_north) + 18'(p.f_northeast) + 18'(p.f_northwest);
    yn = 18'(p.f_south) + 18'(p.f_southwest) + 18'(p.f_southeast);
    m.vel_x = velocity_q(xp, xn, rho, ax);
    m.vel_y = velocity_q(yp, yn, rho, ay);
    if (grid_fresh) begin
      grid_min = rho;
      grid_max = rho;
      grid_peak_vx = ax;
      grid_peak_vy = ay;
    end else begin
      if (rho < grid_min) grid_min = rho;
      if (rho > grid_max) grid_max = rho;
      if (ax > grid_peak_vx) grid_peak_vx = ax;
      if (ay > grid_peak_vy) grid_peak_vy = ay;
    end
    m.density = rho;
    m.density_min = grid_min;
    m.density_max = grid_max;
    m.peak_abs_vx = grid_peak_vx;
    m.peak_abs_vy = grid_peak_vy;
    m.zero_density = (rho == '0);
    m.grid_done = is_last;
    pending_moments.push_back(m);
    n_cells++;
    if (rho == '0) n_zero_cells++;
    if (is_last) begin
      grid_min = '0;
      grid_max = '0;
      grid_peak_vx = '0;
      grid_peak_vy = '0;
      grid_fresh = 1'b1;
      n_grids++;
    end else begin
      grid_fresh = 1'b0;
    end
  endfunction

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_cell(input pops_t p, input logic is_last);
    bit          taken;
    int unsigned waited;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= p;
    s_axis_tlast_i <= is_last;
    taken = 1'b0;
    waited = 0;
    while (!taken) begin
      @(negedge clk_i);
      if (s_axis_tready_o) begin
        taken = 1'b1;
        predict_cell(p, is_last);
      end else begin
        waited++;
      end
      @(posedge clk_i);
    end
    if (waited > longest_in_stall) longest_in_stall = waited;
  endtask

  function automatic pops_t mk_pops(input logic [FW-1:0] r, e, n, w, s, ne, nw, sw, se);
    pops_t p;
    p.f_rest = r;
    p.f_east = e;
    p.f_north = n;
    p.f_west = w;
    p.f_south = s;
    p.f_northeast = ne;
    p.f_northwest = nw;
    p.f_southwest = sw;
    p.f_southeast = se;
    return p;
  endfunction

  function automatic pops_t random_cell();
    pops_t         p;
    gen_mode_e     mode;
    logic [FW-1:0] v[9];
    int unsigned   hot;
    mode = gen_mode_e'($urandom_range(0, 5) > 4 ? 0 : $urandom_range(0, 4));
    hot = $urandom_range(1, 8);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        GEN_FULL: begin
          v[i] = FW'($urandom);
        end
        GEN_SMALL: begin
          v[i] = FW'($urandom_range(0, 15));
        end
        GEN_DRIFT: begin
          v[i] = (i == hot) ? FW'($urandom_range(32768, 65535)) : FW'($urandom_range(0, 255));
        end
        GEN_SPARSE: begin
          v[i] = ($urandom_range(0, 2) == 0) ? FW'($urandom) : '0;
        end
        default: begin
          v[i] = (i == 0) ? FW'($urandom_range(40000, 65535)) : FW'($urandom_range(0, 4000));
        end
      endcase
    end
    // an occasional empty cell
    if ($urandom_range(0, 40) == 0) begin
      foreach (v[i]) v[i] = '0;
    end
    p = mk_pops(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    return p;
  endfunction

  // output side: a transaction happens at the next rising edge when both are high here
  initial begin
    moments_t m;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        n_checked++;
        if (pending_moments.size() == 0) begin
          report_mismatch("result with no cell outstanding");
        end else begin
          m = pending_moments.pop_front();
          check_field("density", 32'(m_axis_tdata_o[19:0]), 32'(m.density));
          check_field("vel_x", 32'(m_axis_tdata_o[35:20]), 32'(m.vel_x));
          check_field("vel_y", 32'(m_axis_tdata_o[51:36]), 32'(m.vel_y));
          check_field("density_min", 32'(m_axis_tdata_o[71:52]), 32'(m.density_min));
          check_field("density_max", 32'(m_axis_tdata_o[91:72]), 32'(m.density_max));
          check_field("peak_abs_vx", 32'(m_axis_tdata_o[107:92]), 32'(m.peak_abs_vx));
          check_field("peak_abs_vy", 32'(m_axis_tdata_o[123:108]), 32'(m.peak_abs_vy));
          check_field("tdata padding", 32'(m_axis_tdata_o[127:124]), 32'd0);
          check_field("zero_density", 32'(m_axis_tuser_o), 32'(m.zero_density));
          check_field("grid_done", 32'(m_axis_tlast_o), 32'(m.grid_done));
        end
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned gap_left;
    hold_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(1, 13) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic test_direction_extremes();
    send_cell(mk_pops('0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops('1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b0);
    send_cell(mk_pops('1, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops('0, '1, '0, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops('0, '0, '1, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops('0, '0, '0, '1, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops('0, '0, '0, '0, '1, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops('0, '0, '0, '0, '0, '1, '0, '0, '0), 1'b0);
    send_cell(mk_pops('0, '0, '0, '0, '0, '0, '1, '0, '0), 1'b0);
    send_cell(mk_pops('0, '0, '0, '0, '0, '0, '0, '1, '0), 1'b0);
    send_cell(mk_pops('0, '0, '0, '0, '0, '0, '0, '0, '1), 1'b0);
    send_cell(mk_pops(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                      16'haaaa, 16'h5555, 16'haaaa, 16'h5555), 1'b1);
  endtask

  task automatic test_rounding_and_zero();
    send_cell(mk_pops(16'd2, 16'd1, '0, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops(16'd2, '0, '0, 16'd1, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops('1, 16'd3, 16'd1, 16'd1, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops('0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops(16'd7, '0, '0, '0, '0, '0, '0, 16'd1, '0), 1'b1);
  endtask

  task automatic test_grid_restart();
    send_cell(mk_pops('1, '0, '1, '0, '0, '0, '0, '0, '0), 1'b1);
    send_cell(mk_pops('0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1);
    send_cell(mk_pops(16'd100, '0, '0, '0, '0, '0, '0, '0, 16'd50), 1'b1);
    send_cell(mk_pops('1, '1, '0, '0, '0, '0, '0, '0, '0), 1'b0);
    send_cell(mk_pops(16'd10, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1);
    send_cell(mk_pops(16'd1, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
  endtask

  task automatic test_output_stall();
    tx_idle_en = 1'b0;
    hold_request = 300;
    for (int i = 0; i < 15; i++) begin
      send_cell(random_cell(), i == 14);
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_grids();
    int unsigned sent;
    int unsigned grid_len;
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      grid_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      for (int i = 0; i < grid_len; i++) begin
        send_cell(random_cell(), i == grid_len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_streaming_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < STREAM_CELLS; i++) begin
      send_cell(random_cell(), $urandom_range(0, 9) == 0);
    end
    send_cell(random_cell(), 1'b1);
  endtask

  initial begin
    int unsigned drain_cycles;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_direction_extremes();
    test_rounding_and_zero();
    test_grid_restart();
    test_output_stall();
    test_random_grids();
    test_streaming_no_idle();

    s_axis_tvalid_i <= 1'b0;
    drain_cycles = 0;
    while (pending_moments.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_moments.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_moments.size()));
    end

    $display("%0d cells in %0d grids checked against %0d results, %0d of zero density",
             n_cells, n_grids, n_checked, n_zero_cells);
    $display("directions, truncation, grid restarts, random stalls; longest input stall %0d",
             longest_in_stall);
    if (n_errors == 0) begin
      $display("d2q9_moments_with_reduction regression: pass");
    end else begin
      $display("d2q9_moments_with_reduction regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/d2q9m_pkg.sv
hw/rtl/d2q9_moments_with_reduction.sv
tb/sv/d2q9_moments_with_reduction_tb.sv
